// ===== hw/rtl/dpmm_pkg.sv =====
// dpmm_pkg: word types, register indexes and fixed-point constants for the
// drive PID motor mix unit. No dependencies.
`default_nettype none

package dpmm_pkg;

  localparam int DEG_W     = 24;   // encoder position, signed degrees
  localparam int GAIN_W    = 16;   // unsigned Q4.12 gain
  localparam int PCT_W     = 8;    // signed percent command
  localparam int ERR_W     = 28;   // error in quarter degrees
  localparam int DERIV_W   = ERR_W + 1;
  localparam int INTEG_W   = 48;
  localparam int PTERM_W   = GAIN_W + 1 + ERR_W;
  localparam int DTERM_W   = GAIN_W + 1 + DERIV_W;
  localparam int IHALF_W   = INTEG_W / 2;
  localparam int IPART_W   = IHALF_W + GAIN_W;
  localparam int IPROD_W   = INTEG_W + GAIN_W;
  localparam int ITERM_W   = 47;   // clamped integral magnitude, up to 2^46
  localparam int SUM_W     = 49;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam int PCT_SHIFT  = 14;  // power = sum / 2^14
  localparam int PCT_MAX    = 100;
  localparam int HALT_PCT   = 50;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 16'd1024;  // 0.25
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 16'd389;   // about 0.095
  localparam logic [DEG_W-1:0]   TARGET_RST     = 24'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_PROP  = 2'd0,
    CFG_GAIN_INTEG = 2'd1,
    CFG_GAIN_DERIV = 2'd2,
    CFG_TARGET_DEG = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] left_big_deg;
    logic signed [DEG_W-1:0] right_big_deg;
    logic signed [DEG_W-1:0] left_small_deg;
    logic signed [DEG_W-1:0] right_small_deg;
  } in_word_t;

  typedef struct packed {
    logic signed [PCT_W-1:0] big_drive_pct;
    logic signed [PCT_W-1:0] small_drive_pct;
    logic                    small_halted;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drive_pid_motor_mix_unit.sv =====
// drive_pid_motor_mix_unit: position PID over four wheel encoders with a
// big/small motor mix. Depends on dpmm_pkg.
`default_nettype none

//  channel  | handshake                | payload              | dir
//  ---------+--------------------------+----------------------+-----
//  in       | in_valid / in_ready      | in_data  (in_word_t) | in
//  out      | out_valid / out_ready    | out_data (out_word_t)| out
//  cfg      | cfg_wr_en (no wait)      | cfg_addr, cfg_wdata  | in
//
//  Seven register stages, one word per cycle sustained while out_ready is
//  high. The depth is set by the integral path: saturating add, magnitude,
//  split 48x16 multiply, clamp, three-way add, scale and clamp.
//  rst (synchronous) clears the gains and set point to their defaults, the integral and the
//  stored error, and empties the pipe. A stalled output holds its word; each
//  stage keeps taking words while it has a hole, so in_ready drops only when
//  every stage is full and out_ready is low.

module drive_pid_motor_mix_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire dpmm_pkg::in_word_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output dpmm_pkg::out_word_t                      out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dpmm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [dpmm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NSTG = 6;

  // configuration registers
  logic        [dpmm_pkg::GAIN_W-1:0] gain_prop;
  logic        [dpmm_pkg::GAIN_W-1:0] gain_integ;
  logic        [dpmm_pkg::GAIN_W-1:0] gain_deriv;
  logic signed [dpmm_pkg::DEG_W-1:0]  target_deg;

  // loop state
  logic signed [dpmm_pkg::INTEG_W-1:0] integ_sum;
  logic signed [dpmm_pkg::ERR_W-1:0]   last_error;

  // pipe control: stage_vld[k] is the valid bit of stage k, adv[k] lets it load
  logic [NSTG:1]   stage_vld;
  logic [NSTG+1:1] adv;

  always_comb begin
    adv[NSTG+1] = !out_valid || out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !stage_vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[1]) begin
        stage_vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          stage_vld[k] <= stage_vld[k-1];
        end
      end
      if (adv[NSTG+1]) begin
        out_valid <= stage_vld[NSTG];
      end
    end
  end

  // ---- configuration writes (to be made only while idle; the block does not enforce this) ----
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= dpmm_pkg::GAIN_PROP_RST;
      gain_integ <= dpmm_pkg::GAIN_INTEG_RST;
      gain_deriv <= dpmm_pkg::GAIN_DERIV_RST;
      target_deg <= dpmm_pkg::TARGET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        dpmm_pkg::CFG_GAIN_PROP:  gain_prop  <= cfg_wdata[dpmm_pkg::GAIN_W-1:0];
        dpmm_pkg::CFG_GAIN_INTEG: gain_integ <= cfg_wdata[dpmm_pkg::GAIN_W-1:0];
        dpmm_pkg::CFG_GAIN_DERIV: gain_deriv <= cfg_wdata[dpmm_pkg::GAIN_W-1:0];
        dpmm_pkg::CFG_TARGET_DEG: target_deg <= cfg_wdata[dpmm_pkg::DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- stage 1: input register ----
  dpmm_pkg::in_word_t s1_word;

  always_ff @(posedge clk) begin
    if (adv[1] && in_valid) begin
      s1_word <= in_data;
    end
  end

  // ---- stage 2: error, derivative, saturating integral ----
  localparam int XW = dpmm_pkg::ERR_W - dpmm_pkg::DEG_W;

  logic signed [dpmm_pkg::ERR_W-1:0]   lb_x, rb_x, ls_x, rs_x, tg_x, err_now;
  logic signed [dpmm_pkg::DERIV_W-1:0] deriv_now;
  logic signed [dpmm_pkg::INTEG_W:0]   integ_wide;
  logic signed [dpmm_pkg::INTEG_W-1:0] integ_sum_next;
  logic                                step;

  assign step = adv[2] && stage_vld[1];

  always_comb begin
    lb_x = {{XW{s1_word.left_big_deg[dpmm_pkg::DEG_W-1]}},    s1_word.left_big_deg};
    rb_x = {{XW{s1_word.right_big_deg[dpmm_pkg::DEG_W-1]}},   s1_word.right_big_deg};
    ls_x = {{XW{s1_word.left_small_deg[dpmm_pkg::DEG_W-1]}},  s1_word.left_small_deg};
    rs_x = {{XW{s1_word.right_small_deg[dpmm_pkg::DEG_W-1]}}, s1_word.right_small_deg};
    tg_x = {{XW{target_deg[dpmm_pkg::DEG_W-1]}}, target_deg};
    // quarter degrees: small wheels count twice, set point four times
    err_now   = lb_x + rb_x + ((ls_x + rs_x) <<< 1) - (tg_x <<< 2);
    deriv_now = {err_now[dpmm_pkg::ERR_W-1], err_now}
              - {last_error[dpmm_pkg::ERR_W-1], last_error};
    integ_wide = {integ_sum[dpmm_pkg::INTEG_W-1], integ_sum}
               + {{(dpmm_pkg::INTEG_W+1-dpmm_pkg::ERR_W){err_now[dpmm_pkg::ERR_W-1]}},
                  err_now};
    // top two bits disagree: overflow, pin to the rail on the true sign
    if (integ_wide[dpmm_pkg::INTEG_W] != integ_wide[dpmm_pkg::INTEG_W-1]) begin
      integ_sum_next = integ_wide[dpmm_pkg::INTEG_W]
                     ? {1'b1, {(dpmm_pkg::INTEG_W-1){1'b0}}}
                     : {1'b0, {(dpmm_pkg::INTEG_W-1){1'b1}}};
    end else begin
      integ_sum_next = integ_wide[dpmm_pkg::INTEG_W-1:0];
    end
  end

  logic signed [dpmm_pkg::ERR_W-1:0]   s2_err;
  logic signed [dpmm_pkg::DERIV_W-1:0] s2_deriv;
  logic signed [dpmm_pkg::INTEG_W-1:0] s2_integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum  <= '0;
      last_error <= '0;
    end else if (step) begin
      integ_sum  <= integ_sum_next;
      last_error <= err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_err   <= err_now;
      s2_deriv <= deriv_now;
      s2_integ <= integ_sum_next;
    end
  end

  // ---- stage 3: P and D products, integral magnitude ----
  logic signed [dpmm_pkg::PTERM_W-1:0] s3_pterm;
  logic signed [dpmm_pkg::DTERM_W-1:0] s3_dterm;
  logic        [dpmm_pkg::INTEG_W-1:0] s3_imag;
  logic                                s3_ineg;

  always_ff @(posedge clk) begin
    if (adv[3] && stage_vld[2]) begin
      s3_pterm <= $signed({1'b0, gain_prop}) * s2_err;
      s3_dterm <= $signed({1'b0, gain_deriv}) * s2_deriv;
      s3_imag  <= s2_integ[dpmm_pkg::INTEG_W-1] ? 48'(-s2_integ) : 48'(s2_integ);
      s3_ineg  <= s2_integ[dpmm_pkg::INTEG_W-1];
    end
  end

  // ---- stage 4: integral product as two 24x16 halves ----
  logic signed [dpmm_pkg::PTERM_W-1:0] s4_pterm;
  logic signed [dpmm_pkg::DTERM_W-1:0] s4_dterm;
  logic        [dpmm_pkg::IPART_W-1:0] s4_ilo, s4_ihi;
  logic                                s4_ineg;

  always_ff @(posedge clk) begin
    if (adv[4] && stage_vld[3]) begin
      s4_pterm <= s3_pterm;
      s4_dterm <= s3_dterm;
      s4_ilo   <= s3_imag[dpmm_pkg::IHALF_W-1:0] * gain_integ;
      s4_ihi   <= s3_imag[dpmm_pkg::INTEG_W-1:dpmm_pkg::IHALF_W] * gain_integ;
      s4_ineg  <= s3_ineg;
    end
  end

  // ---- stage 5: join halves, clamp magnitude to 2^46 ----
  localparam logic [dpmm_pkg::IPROD_W-1:0] ITERM_LIM =
    dpmm_pkg::IPROD_W'(1) << (dpmm_pkg::ITERM_W - 1);

  logic [dpmm_pkg::IPROD_W-1:0] iprod;

  assign iprod = ({{(dpmm_pkg::IPROD_W-dpmm_pkg::IPART_W){1'b0}}, s4_ihi}
                  << dpmm_pkg::IHALF_W)
               + {{(dpmm_pkg::IPROD_W-dpmm_pkg::IPART_W){1'b0}}, s4_ilo};

  logic signed [dpmm_pkg::PTERM_W-1:0] s5_pterm;
  logic signed [dpmm_pkg::DTERM_W-1:0] s5_dterm;
  logic        [dpmm_pkg::ITERM_W-1:0] s5_imag;
  logic                                s5_ineg;

  always_ff @(posedge clk) begin
    if (adv[5] && stage_vld[4]) begin
      s5_pterm <= s4_pterm;
      s5_dterm <= s4_dterm;
      s5_imag  <= (iprod > ITERM_LIM) ? ITERM_LIM[dpmm_pkg::ITERM_W-1:0]
                                      : iprod[dpmm_pkg::ITERM_W-1:0];
      s5_ineg  <= s4_ineg;
    end
  end

  // ---- stage 6: PID sum ----
  logic signed [dpmm_pkg::SUM_W-1:0] p_x, d_x, i_x;

  always_comb begin
    p_x = {{(dpmm_pkg::SUM_W-dpmm_pkg::PTERM_W){s5_pterm[dpmm_pkg::PTERM_W-1]}}, s5_pterm};
    d_x = {{(dpmm_pkg::SUM_W-dpmm_pkg::DTERM_W){s5_dterm[dpmm_pkg::DTERM_W-1]}}, s5_dterm};
    // conditional negate folded into the adder: (m ^ s) + s
    i_x = {{(dpmm_pkg::SUM_W-dpmm_pkg::ITERM_W){1'b0}}, s5_imag}
        ^ {dpmm_pkg::SUM_W{s5_ineg}};
  end

  logic signed [dpmm_pkg::SUM_W-1:0] s6_sum;

  always_ff @(posedge clk) begin
    if (adv[6] && stage_vld[5]) begin
      s6_sum <= p_x + d_x + i_x + dpmm_pkg::SUM_W'(s5_ineg);
    end
  end

  // ---- stage 7: scale to percent, halt test, output register ----
  localparam int QB_W = dpmm_pkg::SUM_W - dpmm_pkg::PCT_SHIFT;
  localparam int QS_W = QB_W + 1;
  localparam logic signed [dpmm_pkg::SUM_W-1:0] BIG_BIAS =
    (dpmm_pkg::SUM_W'(1) << dpmm_pkg::PCT_SHIFT) - 1;
  localparam logic signed [dpmm_pkg::SUM_W-1:0] SMALL_BIAS =
    (dpmm_pkg::SUM_W'(1) << (dpmm_pkg::PCT_SHIFT - 1)) - 1;
  localparam logic signed [dpmm_pkg::SUM_W-1:0] HALT_LIM =
    dpmm_pkg::SUM_W'(dpmm_pkg::HALT_PCT) << dpmm_pkg::PCT_SHIFT;

  function automatic logic signed [dpmm_pkg::PCT_W-1:0] clamp_pct(
    input logic signed [QS_W-1:0] v
  );
    if (v > QS_W'(dpmm_pkg::PCT_MAX)) begin
      return dpmm_pkg::PCT_W'(dpmm_pkg::PCT_MAX);
    end else if (v < -QS_W'(dpmm_pkg::PCT_MAX)) begin
      return -dpmm_pkg::PCT_W'(dpmm_pkg::PCT_MAX);
    end else begin
      return v[dpmm_pkg::PCT_W-1:0];
    end
  endfunction

  logic signed [dpmm_pkg::SUM_W-1:0] big_biased, small_biased;
  logic signed [QB_W-1:0]            q_big;
  logic signed [QS_W-1:0]            q_small;
  logic                              halt_now;
  dpmm_pkg::out_word_t               out_next;

  always_comb begin
    // truncate toward zero: bias negatives before the arithmetic shift
    big_biased   = s6_sum[dpmm_pkg::SUM_W-1] ? s6_sum + BIG_BIAS   : s6_sum;
    small_biased = s6_sum[dpmm_pkg::SUM_W-1] ? s6_sum + SMALL_BIAS : s6_sum;
    q_big   = big_biased[dpmm_pkg::SUM_W-1:dpmm_pkg::PCT_SHIFT];
    q_small = small_biased[dpmm_pkg::SUM_W-1:dpmm_pkg::PCT_SHIFT-1];
    halt_now = s6_sum > HALT_LIM;
    out_next.big_drive_pct   = clamp_pct({q_big[QB_W-1], q_big});
    out_next.small_drive_pct = halt_now ? '0 : clamp_pct(q_small);
    out_next.small_halted    = halt_now;
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG+1] && stage_vld[NSTG]) begin
      out_data <= out_next;
    end
  end

  // ---- assertions ----
  a_halt_zeroes_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.small_halted |-> out_data.small_drive_pct == '0)
    else $error("small motors not stopped while halted");

  a_halt_big_power: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.small_halted |-> out_data.big_drive_pct >= 8'sd50)
    else $error("halt raised with big power below 50");

  a_big_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.big_drive_pct <= 8'sd100 && out_data.big_drive_pct >= -8'sd100)
    else $error("big drive out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(integ_sum) && $stable(last_error))
    else $error("loop state changed without a word");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with a free output");

endmodule

`default_nettype wire

// ===== tb/tb_drive_pid_motor_mix_unit.sv =====
// tb_drive_pid_motor_mix_unit: self-checking bench for the drive PID motor mix
// unit. Predicts every command word in-line and checks it against the output.
// Depends on dpmm_pkg and drive_pid_motor_mix_unit only.

module tb_drive_pid_motor_mix_unit;

  localparam longint INTEG_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_BOT = -INTEG_TOP - 1;
  localparam logic [63:0] ITERM_CAP = 64'd1 << 46;
  localparam longint UNIT_PWR = 64'sd1 << dpmm_pkg::PCT_SHIFT;  // one percent of power
  localparam int DEG_HI = 8388607;
  localparam int DEG_LO = -8388608;
  localparam longint STEP_CAP = 64'sd48000000;     // largest error recenter() sends
  localparam int RUN_ITEMS = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dpmm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dpmm_pkg::out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [dpmm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [dpmm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Bench copy of the registers and of the controller state
  int kp = dpmm_pkg::GAIN_PROP_RST;
  int ki = dpmm_pkg::GAIN_INTEG_RST;
  int kd = dpmm_pkg::GAIN_DERIV_RST;
  int set_deg = $signed(dpmm_pkg::TARGET_RST);
  longint integ_acc = 0;
  longint prev_err = 0;

  dpmm_pkg::in_word_t enc_q[$];     // encoder words waiting for the driver
  dpmm_pkg::out_word_t cmd_q[$];    // predicted motor commands, oldest first
  int fails = 0;
  int sent = 0;

  // Idle-burst control; the enables are set between phases by the stimulus process
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  bit quiet = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;

  logic signed [dpmm_pkg::DEG_W-1:0] edge_deg [5] =
    '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  drive_pid_motor_mix_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  function automatic longint pct_clip(longint v);
    if (v > dpmm_pkg::PCT_MAX) return dpmm_pkg::PCT_MAX;
    if (v < -dpmm_pkg::PCT_MAX) return -dpmm_pkg::PCT_MAX;
    return v;
  endfunction

  function automatic logic signed [dpmm_pkg::DEG_W-1:0] deg_clip(longint v);
    if (v > DEG_HI) return dpmm_pkg::DEG_W'(DEG_HI);
    if (v < DEG_LO) return dpmm_pkg::DEG_W'(DEG_LO);
    return dpmm_pkg::DEG_W'(v);
  endfunction

  function automatic longint spread(int r);
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  // One PID tick: error in quarter degrees, saturating integral, derivative
  // against the last error, then the big/small motor mix.
  function automatic dpmm_pkg::out_word_t mix_predict(dpmm_pkg::in_word_t w);
    longint err, rate, drive, iterm;
    logic [63:0] mag, iprod;
    dpmm_pkg::out_word_t r;
    err = longint'($signed(w.left_big_deg)) + longint'($signed(w.right_big_deg))
        + 2 * (longint'($signed(w.left_small_deg)) + longint'($signed(w.right_small_deg)))
        - 4 * longint'(set_deg);
    rate = err - prev_err;
    if (err > 0 && integ_acc > INTEG_TOP - err) integ_acc = INTEG_TOP;
    else if (err < 0 && integ_acc < INTEG_BOT - err) integ_acc = INTEG_BOT;
    else integ_acc += err;
    // integral term is clamped on its magnitude
    mag = (integ_acc < 0) ? -integ_acc : integ_acc;
    iprod = mag * 64'(ki);
    if (iprod > ITERM_CAP) iprod = ITERM_CAP;
    iterm = (integ_acc < 0) ? -longint'(iprod) : longint'(iprod);
    drive = longint'(kp) * err + longint'(kd) * rate + iterm;
    prev_err = err;
    // signed division truncates toward zero on both paths
    r.big_drive_pct = dpmm_pkg::PCT_W'(pct_clip(drive / UNIT_PWR));
    r.small_halted = drive > dpmm_pkg::HALT_PCT * UNIT_PWR;
    r.small_drive_pct = r.small_halted ? '0
                      : dpmm_pkg::PCT_W'(pct_clip(drive / (UNIT_PWR / 2)));
    return r;
  endfunction

  // Encoder word that yields error e under the current set point
  function automatic dpmm_pkg::in_word_t word_for_err(longint e);
    longint s, q, d;
    dpmm_pkg::in_word_t w;
    s = e + 4 * longint'(set_deg);
    q = s / 6;
    d = spread(100);
    w.left_big_deg = dpmm_pkg::DEG_W'(q + d + (s - 6 * q));
    w.right_big_deg = dpmm_pkg::DEG_W'(q - d);
    w.left_small_deg = dpmm_pkg::DEG_W'(q);
    w.right_small_deg = dpmm_pkg::DEG_W'(q);
    return w;
  endfunction

  // Register write; the pipe is empty whenever this runs
  task automatic write_reg(dpmm_pkg::cfg_reg_t idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= dpmm_pkg::CFG_DATA_W'(val);
    case (idx)
      dpmm_pkg::CFG_GAIN_PROP:  kp = val & 32'hFFFF;
      dpmm_pkg::CFG_GAIN_INTEG: ki = val & 32'hFFFF;
      dpmm_pkg::CFG_GAIN_DERIV: kd = val & 32'hFFFF;
      dpmm_pkg::CFG_TARGET_DEG: set_deg = $signed(dpmm_pkg::DEG_W'(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_all(int p, int i, int d, int t);
    write_reg(dpmm_pkg::CFG_GAIN_PROP, p);
    write_reg(dpmm_pkg::CFG_GAIN_INTEG, i);
    write_reg(dpmm_pkg::CFG_GAIN_DERIV, d);
    write_reg(dpmm_pkg::CFG_TARGET_DEG, t);
    @(negedge clk);
  endtask

  // Sender holds off until every predicted word has come back, then a margin
  task automatic wait_idle();
    do @(negedge clk); while (enc_q.size() != 0 || in_valid || cmd_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // Walk the integral back to exactly zero with set point 0
  task automatic recenter();
    longint rest, e;
    write_reg(dpmm_pkg::CFG_TARGET_DEG, 0);
    @(negedge clk);
    rest = integ_acc;
    while (rest != 0) begin
      e = (-rest > STEP_CAP) ? STEP_CAP : (-rest < -STEP_CAP) ? -STEP_CAP : -rest;
      enc_q.push_back(word_for_err(e));
      rest += e;
      sent++;
    end
    wait_idle();
  endtask

  // Driver: predicts on accept, then offers the next word or an idle burst
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready)
        cmd_q.push_back(mix_predict(in_data));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (enc_q.size() > 0) begin
          in_data <= enc_q.pop_front();
          in_valid <= 1'b1;
          if (src_idle_en && !quiet && $urandom_range(0, 9) == 0)
            src_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted command word, stalls the output in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, actual %p", $time, out_data);
        end else begin
          automatic dpmm_pkg::out_word_t want = cmd_q.pop_front();
          if (out_data.big_drive_pct !== want.big_drive_pct) begin
            fails++;
            $display("%0t: big_drive_pct expected %0d actual %0d", $time,
                     want.big_drive_pct, out_data.big_drive_pct);
          end
          if (out_data.small_drive_pct !== want.small_drive_pct) begin
            fails++;
            $display("%0t: small_drive_pct expected %0d actual %0d", $time,
                     want.small_drive_pct, out_data.small_drive_pct);
          end
          if (out_data.small_halted !== want.small_halted) begin
            fails++;
            $display("%0t: small_halted expected %0b actual %0b", $time,
                     want.small_halted, out_data.small_halted);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (sink_idle_en && !quiet && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int lot, n, style, spread_r, tgt;
    longint base;
    longint probe [12];
    dpmm_pkg::in_word_t w;

    probe = '{819200, 819201, -819200, -819201, 16383, -16383,
              -16384, 8191, -8191, 1654784, -1654784, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset gains: field extremes and sign mixes
    @(negedge clk);
    enc_q.push_back(dpmm_pkg::in_word_t'('0));
    enc_q.push_back(dpmm_pkg::in_word_t'({4{24'h7FFFFF}}));
    enc_q.push_back(dpmm_pkg::in_word_t'({4{24'h800000}}));
    enc_q.push_back(dpmm_pkg::in_word_t'({24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF}));
    enc_q.push_back(dpmm_pkg::in_word_t'({24'h000001, 24'hFFFFFF, 24'h000002, 24'hFFFFFE}));
    sent += 5;
    wait_idle();

    // Unity proportional gain only: power is error / 2^14, which puts the
    // halt threshold, truncation toward zero and +-100 clipping on exact values
    set_all(1, 0, 0, 0);
    foreach (probe[i]) enc_q.push_back(word_for_err(probe[i]));
    sent += 12;
    wait_idle();

    for (lot = 0; sent < RUN_ITEMS; lot++) begin
      quiet = (sent >= RUN_ITEMS - 100);
      src_idle_en = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;

      if (lot % 5 == 4) begin
        // Windup: large same-sign errors with a big integral gain, far enough
        // to clamp the integral product, then twice as long the other way
        n = $urandom_range(26, 30);
        set_all($urandom_range(0, 4096), $urandom_range(50000, 65535),
                $urandom_range(0, 4096), DEG_LO);
        repeat (n) begin
          w.left_big_deg =
            dpmm_pkg::DEG_W'((1 << 22) + $urandom_range(0, (1 << 22) - 1));
          w.right_big_deg =
            dpmm_pkg::DEG_W'((1 << 22) + $urandom_range(0, (1 << 22) - 1));
          w.left_small_deg =
            dpmm_pkg::DEG_W'((1 << 22) + $urandom_range(0, (1 << 22) - 1));
          w.right_small_deg =
            dpmm_pkg::DEG_W'((1 << 22) + $urandom_range(0, (1 << 22) - 1));
          enc_q.push_back(w);
          sent++;
        end
        wait_idle();
        write_reg(dpmm_pkg::CFG_TARGET_DEG, DEG_HI);
        @(negedge clk);
        repeat (2 * n) begin
          w.left_big_deg =
            dpmm_pkg::DEG_W'(-(1 << 22) - longint'($urandom_range(0, 1 << 22)));
          w.right_big_deg =
            dpmm_pkg::DEG_W'(-(1 << 22) - longint'($urandom_range(0, 1 << 22)));
          w.left_small_deg =
            dpmm_pkg::DEG_W'(-(1 << 22) - longint'($urandom_range(0, 1 << 22)));
          w.right_small_deg =
            dpmm_pkg::DEG_W'(-(1 << 22) - longint'($urandom_range(0, 1 << 22)));
          enc_q.push_back(w);
          sent++;
        end
      end else begin
        tgt = $signed(dpmm_pkg::DEG_W'($urandom));
        case (lot)
          0: set_all(0, 0, 0, DEG_HI);
          1: set_all(65535, 0, 65535, DEG_LO);
          2: set_all(65535, 65535, 0, spread(3000));
          default: set_all($urandom_range(0, 8192),
                           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40),
                           $urandom_range(0, 6000),
                           ($urandom_range(0, 1) == 0) ? spread(3000) : tgt);
        endcase
        // Mostly words that keep the error near zero so the power stays in range;
        // noise and field extremes only where the integral is not in use
        spread_r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20000)
                                               : $urandom_range(1, 400);
        base = (2 * longint'(set_deg)) / 3;
        n = $urandom_range(30, 80);
        repeat (n) begin
          style = $urandom_range(0, 19);
          if (ki == 0 && style < 3) begin
            w = dpmm_pkg::in_word_t'({$urandom, $urandom, $urandom});
          end else if (ki == 0 && style < 5) begin
            w.left_big_deg = edge_deg[$urandom_range(0, 4)];
            w.right_big_deg = edge_deg[$urandom_range(0, 4)];
            w.left_small_deg = edge_deg[$urandom_range(0, 4)];
            w.right_small_deg = edge_deg[$urandom_range(0, 4)];
          end else begin
            w.left_big_deg = deg_clip(base + spread(spread_r));
            w.right_big_deg = deg_clip(base + spread(spread_r));
            w.left_small_deg = deg_clip(base + spread(spread_r));
            w.right_small_deg = deg_clip(base + spread(spread_r));
          end
          enc_q.push_back(w);
          sent++;
        end
      end
      wait_idle();
      if (integ_acc > 4096 || integ_acc < -4096)
        recenter();
    end

    if (fails == 0)
      $display("tb_drive_pid_motor_mix_unit OK");
    else
      $display("tb_drive_pid_motor_mix_unit NOT OK");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_drive_pid_motor_mix_unit NOT OK");
    $finish;
  end

endmodule
